// File: hdl/qmn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qmn_pkg;

   // one product term of the hamilton product: a operand, b operand, subtract
   typedef struct packed {
      logic [2:0] a_sel;
      logic [2:0] b_sel;
      logic       sub;
   } term_type;

   // operand order: a_x a_y a_z a_w b_x b_y b_z b_w
   localparam int NUM_OPS   = 8;
   localparam int NUM_COMPS = 4;
   localparam int NUM_TERMS = 4;

   typedef term_type term_tab_type [NUM_COMPS][NUM_TERMS];

   localparam term_tab_type TERM_TAB = '{
      '{'{3'd3, 3'd4, 1'b0}, '{3'd7, 3'd0, 1'b0}, '{3'd1, 3'd6, 1'b0}, '{3'd2, 3'd5, 1'b1}},
      '{'{3'd3, 3'd5, 1'b0}, '{3'd7, 3'd1, 1'b0}, '{3'd2, 3'd4, 1'b0}, '{3'd0, 3'd6, 1'b1}},
      '{'{3'd3, 3'd6, 1'b0}, '{3'd7, 3'd2, 1'b0}, '{3'd0, 3'd5, 1'b0}, '{3'd1, 3'd4, 1'b1}},
      '{'{3'd3, 3'd7, 1'b0}, '{3'd0, 3'd4, 1'b1}, '{3'd1, 3'd5, 1'b1}, '{3'd2, 3'd6, 1'b1}}
   };

   localparam int COMP_W = 3;

endpackage
`default_nettype wire

// File: hdl/quaternion_multiply_normalize.sv
`timescale 1ns / 1ps
`default_nettype none
// Normalized Hamilton product r = (a*b)/|a*b| on signed fixed-point quaternions (Q2.30 by
// default). A beat enters every cycle while the output is not stalled. It passes six
// front stages (16 products, component sums, magnitude, square partial products, squares,
// sum of squares), one stage per quotient bit of the exact divide-by-norm (FRAC_BITS+1
// shift/add/compare stages, no multipliers), and the output register that applies sign,
// the w >= 0 flip and saturation. The whole pipe holds as one when the output beat is
// stalled, so req_stall follows rsp_stall in the same cycle while a result waits. An all
// zero product returns the identity quaternion with zero_norm set.
module quaternion_multiply_normalize #(
   parameter int FRAC_BITS  = 30,
   parameter int COMP_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [COMP_WIDTH-1:0]   req_a_x,
   input  wire logic [COMP_WIDTH-1:0]   req_a_y,
   input  wire logic [COMP_WIDTH-1:0]   req_a_z,
   input  wire logic [COMP_WIDTH-1:0]   req_a_w,
   input  wire logic [COMP_WIDTH-1:0]   req_b_x,
   input  wire logic [COMP_WIDTH-1:0]   req_b_y,
   input  wire logic [COMP_WIDTH-1:0]   req_b_z,
   input  wire logic [COMP_WIDTH-1:0]   req_b_w,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [COMP_WIDTH-1:0]        rsp_r_x,
   output logic [COMP_WIDTH-1:0]        rsp_r_y,
   output logic [COMP_WIDTH-1:0]        rsp_r_z,
   output logic [COMP_WIDTH-2:0]        rsp_r_w,
   output logic                         rsp_zero_norm
);
   import qmn_pkg::*;

   localparam int W   = COMP_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int PRW = 2 * W;          // one operand product
   localparam int PW  = 2 * W + 2;      // signed component sum, never wraps
   localparam int MW  = 2 * W + 1;      // component magnitude
   localparam int SQW = 4 * W + 2;      // magnitude squared
   localparam int SW  = 4 * W + 4;      // sum of squares
   localparam int XW  = SW + 2 * F + 3; // divider working width
   localparam int NW  = F + 1;          // quotient bits
   localparam int CW  = NW + W;         // clamp compare width
   localparam int NSTG = F + 1;         // quotient stages

   logic adv;
   logic [W-1:0] ops [NUM_OPS];

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   assign ops[0] = req_a_x;
   assign ops[1] = req_a_y;
   assign ops[2] = req_a_z;
   assign ops[3] = req_a_w;
   assign ops[4] = req_b_x;
   assign ops[5] = req_b_y;
   assign ops[6] = req_b_z;
   assign ops[7] = req_b_w;

   // stage 1: sixteen signed products
   logic                  v1_ff;
   logic signed [PRW-1:0] prod_ff [NUM_COMPS][NUM_TERMS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < NUM_COMPS; c++) begin
            for (int t = 0; t < NUM_TERMS; t++) begin
               prod_ff[c][t] <= $signed(ops[TERM_TAB[c][t].a_sel])
                              * $signed(ops[TERM_TAB[c][t].b_sel]);
            end
         end
      end
   end

   // stage 2: signed component sums
   logic                 v2_ff;
   logic signed [PW-1:0] p_ff [NUM_COMPS];
   logic signed [PW-1:0] p_in [NUM_COMPS];

   always_comb begin
      for (int c = 0; c < NUM_COMPS; c++) begin
         p_in[c] = '0;
         for (int t = 0; t < NUM_TERMS; t++) begin
            if (TERM_TAB[c][t].sub) begin
               p_in[c] = p_in[c] - PW'(prod_ff[c][t]);
            end else begin
               p_in[c] = p_in[c] + PW'(prod_ff[c][t]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff <= p_in;
      end
   end

   // stage 3: magnitude and sign; sign of w decides the final flip
   logic                 v3_ff;
   logic [MW-1:0]        mag_ff [NUM_COMPS];
   logic [NUM_COMPS-1:0] neg3_ff;
   logic [PW-1:0]        pabs [NUM_COMPS];

   always_comb begin
      for (int c = 0; c < NUM_COMPS; c++) begin
         pabs[c] = p_ff[c][PW-1] ? PW'(-p_ff[c]) : PW'(p_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < NUM_COMPS; c++) begin
            mag_ff[c]  <= pabs[c][MW-1:0];
            neg3_ff[c] <= p_ff[c][PW-1];
         end
      end
   end

   // stage 4: partial products of the square, split at bit W
   logic                 v4_ff;
   logic [2*W+1:0]       hh_ff [NUM_COMPS];
   logic [2*W:0]         hl_ff [NUM_COMPS];
   logic [2*W-1:0]       ll_ff [NUM_COMPS];
   logic [NUM_COMPS-1:0] neg4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg4_ff <= neg3_ff;
         for (int c = 0; c < NUM_COMPS; c++) begin
            hh_ff[c] <= (2*W+2)'(mag_ff[c][MW-1:W]) * (2*W+2)'(mag_ff[c][MW-1:W]);
            hl_ff[c] <= (2*W+1)'(mag_ff[c][MW-1:W]) * (2*W+1)'(mag_ff[c][W-1:0]);
            ll_ff[c] <= (2*W)'(mag_ff[c][W-1:0]) * (2*W)'(mag_ff[c][W-1:0]);
         end
      end
   end

   // stage 5: squares
   logic                 v5_ff;
   logic [SQW-1:0]       sq_ff [NUM_COMPS];
   logic [NUM_COMPS-1:0] neg5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg5_ff <= neg4_ff;
         for (int c = 0; c < NUM_COMPS; c++) begin
            sq_ff[c] <= (SQW'(hh_ff[c]) << (2 * W)) + (SQW'(hl_ff[c]) << (W + 1))
                      + SQW'(ll_ff[c]);
         end
      end
   end

   // stage 6: sum of squares; then the quotient stages, one bit each, msb first
   // keeps e = m^2*2^2F - n^2*S and t = n*S so each bit is shifts and adds
   logic                 it_v_ff    [0:NSTG];
   logic                 it_zero_ff [0:NSTG];
   logic [NUM_COMPS-1:0] it_neg_ff  [0:NSTG];
   logic [SW-1:0]        it_s_ff    [0:NSTG];
   logic [XW-1:0]        it_e_ff    [0:NSTG][NUM_COMPS];
   logic [XW-1:0]        it_t_ff    [0:NSTG][NUM_COMPS];
   logic [NW-1:0]        it_n_ff    [0:NSTG][NUM_COMPS];
   logic [SW-1:0]        s_in;

   assign s_in = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]) + SW'(sq_ff[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         it_v_ff[0] <= 1'b0;
      end else if (adv) begin
         it_v_ff[0] <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it_zero_ff[0] <= (s_in == '0);
         it_neg_ff[0]  <= neg5_ff;
         it_s_ff[0]    <= s_in;
         for (int c = 0; c < NUM_COMPS; c++) begin
            it_e_ff[0][c] <= XW'(sq_ff[c]) << (2 * F);
            it_t_ff[0][c] <= '0;
            it_n_ff[0][c] <= '0;
         end
      end
   end

   for (genvar k = 0; k < NSTG; k++) begin : g_div
      localparam int B = F - k;
      logic [XW-1:0]        dlt  [NUM_COMPS];
      logic [NUM_COMPS-1:0] take;

      always_comb begin
         for (int c = 0; c < NUM_COMPS; c++) begin
            dlt[c]  = (it_t_ff[k][c] << (B + 1)) + (XW'(it_s_ff[k]) << (2 * B));
            take[c] = (dlt[c] <= it_e_ff[k][c]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            it_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            it_v_ff[k+1] <= it_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            it_zero_ff[k+1] <= it_zero_ff[k];
            it_neg_ff[k+1]  <= it_neg_ff[k];
            it_s_ff[k+1]    <= it_s_ff[k];
            for (int c = 0; c < NUM_COMPS; c++) begin
               if (take[c]) begin
                  it_e_ff[k+1][c] <= it_e_ff[k][c] - dlt[c];
                  it_t_ff[k+1][c] <= it_t_ff[k][c] + (XW'(it_s_ff[k]) << B);
                  it_n_ff[k+1][c] <= it_n_ff[k][c] | (NW'(1) << B);
               end else begin
                  it_e_ff[k+1][c] <= it_e_ff[k][c];
                  it_t_ff[k+1][c] <= it_t_ff[k][c];
                  it_n_ff[k+1][c] <= it_n_ff[k][c];
               end
            end
         end
      end
   end

   // output stage: sign, w flip, saturation, identity on zero norm
   logic          rsp_valid_ff;
   logic [W-1:0]  r_ff [NUM_COMPS];
   logic          zero_ff;
   logic [W-1:0]  r_in [NUM_COMPS];
   logic [CW-1:0] nx [NUM_COMPS];
   logic [CW-1:0] lim_neg;
   logic [CW-1:0] lim_pos;
   logic          flip;
   logic          neg_fin;

   assign lim_neg = CW'(1) << (W - 1);
   assign lim_pos = lim_neg - CW'(1);
   assign flip    = it_neg_ff[NSTG][COMP_W];

   always_comb begin
      neg_fin = 1'b0;
      for (int c = 0; c < NUM_COMPS; c++) begin
         if (it_zero_ff[NSTG]) begin
            // identity: w carries one, vector part zero
            nx[c] = (c == COMP_W) ? (CW'(1) << F) : '0;
         end else begin
            nx[c] = CW'(it_n_ff[NSTG][c]);
         end
         neg_fin = (c != COMP_W) && !it_zero_ff[NSTG] && (it_neg_ff[NSTG][c] ^ flip);
         if (neg_fin) begin
            r_in[c] = (nx[c] > lim_neg) ? lim_neg[W-1:0] : W'(-nx[c]);
         end else begin
            r_in[c] = (nx[c] > lim_pos) ? lim_pos[W-1:0] : nx[c][W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= it_v_ff[NSTG];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff    <= r_in;
         zero_ff <= it_zero_ff[NSTG];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_r_x       = r_ff[0];
   assign rsp_r_y       = r_ff[1];
   assign rsp_r_z       = r_ff[2];
   assign rsp_r_w       = r_ff[COMP_W][W-2:0];
   assign rsp_zero_norm = zero_ff;

   // an accepted beat shows up in the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted beat missing from first stage");

   // identity result carries a zero vector part
   a_ident: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_norm) |-> (rsp_r_x == '0 && rsp_r_y == '0 && rsp_r_z == '0))
      else $error("zero norm result with nonzero vector part");

   // a held pipe keeps its divider front stage
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(it_v_ff[0]))
      else $error("pipe moved while stalled");

endmodule
`default_nettype wire

// File: tb/quaternion_multiply_normalize_tb.sv
`timescale 1ns / 1ps
module quaternion_multiply_normalize_tb;
   import qmn_pkg::*;

   localparam int FRAC_BITS  = 30;
   localparam int COMP_WIDTH = 32;
   // front stages, one stage per quotient bit, output register
   localparam int PIPE_DEPTH = FRAC_BITS + 8;
   localparam int CYCLE_LIMIT = 1000000;

   typedef logic [COMP_WIDTH-1:0] quat_pair_type [NUM_OPS];

   typedef struct {
      logic [COMP_WIDTH-1:0] x;
      logic [COMP_WIDTH-1:0] y;
      logic [COMP_WIDTH-1:0] z;
      logic [COMP_WIDTH-2:0] w;
      logic                  zn;
   } unit_quat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [COMP_WIDTH-1:0] req_a_x = '0, req_a_y = '0, req_a_z = '0, req_a_w = '0;
   logic [COMP_WIDTH-1:0] req_b_x = '0, req_b_y = '0, req_b_z = '0, req_b_w = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [COMP_WIDTH-1:0] rsp_r_x, rsp_r_y, rsp_r_z;
   logic [COMP_WIDTH-2:0] rsp_r_w;
   logic rsp_zero_norm;

   unit_quat_type expected_rots[$];
   int errors = 0;
   int cycles = 0;
   bit no_idle = 1'b0;       // both sides run flat out
   bit hold_request = 1'b0;  // receiver takes one long break
   int hold_left = 0;
   int stall_left = 0;

   quaternion_multiply_normalize #(
      .FRAC_BITS(FRAC_BITS),
      .COMP_WIDTH(COMP_WIDTH)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_a_z(req_a_z), .req_a_w(req_a_w),
      .req_b_x(req_b_x), .req_b_y(req_b_y), .req_b_z(req_b_z), .req_b_w(req_b_w),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_r_x(rsp_r_x), .rsp_r_y(rsp_r_y), .rsp_r_z(rsp_r_z), .rsp_r_w(rsp_r_w),
      .rsp_zero_norm(rsp_zero_norm)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // exact hamilton product, then exact divide by the norm, truncated toward zero
   function automatic unit_quat_type normalized_product(input quat_pair_type op);
      logic signed [67:0]  acc;
      logic signed [63:0]  pa, pb, prod;
      logic [67:0]         mag [NUM_COMPS];
      logic                neg [NUM_COMPS];
      logic [255:0]        sq [NUM_COMPS];
      logic [255:0]        total, rhs, cand;
      logic [31:0]         n;
      longint              res [NUM_COMPS];
      unit_quat_type       r;
      total = '0;
      for (int c = 0; c < NUM_COMPS; c++) begin
         acc = '0;
         for (int t = 0; t < NUM_TERMS; t++) begin
            pa = signed'(op[TERM_TAB[c][t].a_sel]);
            pb = signed'(op[TERM_TAB[c][t].b_sel]);
            prod = pa * pb;
            if (TERM_TAB[c][t].sub)
               acc = acc - prod;
            else
               acc = acc + prod;
         end
         neg[c] = acc < 0;
         mag[c] = neg[c] ? -acc : acc;
         sq[c] = 256'(mag[c]) * 256'(mag[c]);
         total = total + sq[c];
      end
      if (total == '0) begin
         // identity quaternion with the flag raised
         r.x = '0;
         r.y = '0;
         r.z = '0;
         r.w = 31'(longint'(1) << FRAC_BITS);
         r.zn = 1'b1;
         return r;
      end
      for (int c = 0; c < NUM_COMPS; c++) begin
         rhs = sq[c] << (2 * FRAC_BITS);
         n = '0;
         for (int b = FRAC_BITS; b >= 0; b--) begin
            cand = 256'(n | (32'd1 << b));
            if (cand * cand * total <= rhs)
               n = cand[31:0];
         end
         res[c] = neg[c] ? -longint'(n) : longint'(n);
      end
      // keep w non-negative; a zero scalar is left alone
      if (neg[3] && mag[3] != '0)
         for (int c = 0; c < NUM_COMPS; c++)
            res[c] = -res[c];
      // quotient never exceeds 2^31-1, so saturation has nothing to clamp here
      r.x = res[0][31:0];
      r.y = res[1][31:0];
      r.z = res[2][31:0];
      r.w = res[3][30:0];
      r.zn = 1'b0;
      return r;
   endfunction

   function automatic int pick_gap();
      int p;
      if (no_idle)
         return 0;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // offer one beat, wait for it to be taken, then maybe idle
   task automatic send_quat(input quat_pair_type q);
      int gap;
      req_valid <= 1'b1;
      req_a_x <= q[0]; req_a_y <= q[1]; req_a_z <= q[2]; req_a_w <= q[3];
      req_b_x <= q[4]; req_b_y <= q[5]; req_b_z <= q[6]; req_b_w <= q[7];
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expected_rots.push_back(normalized_product(q));
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] rand_comp();
      int p;
      p = $urandom_range(0, 9);
      case (p)
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return 32'(signed'($urandom_range(0, 8)) - 4) <<< FRAC_BITS;
         4: return 32'(signed'($urandom_range(0, 64)) - 32);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_zero_product();
      quat_pair_type q;
      foreach (q[i]) q[i] = '0;
      send_quat(q);
      // zero b with a full-scale a
      foreach (q[i]) q[i] = (i < 4) ? 32'h7fff_ffff : '0;
      send_quat(q);
      foreach (q[i]) q[i] = (i < 4) ? '0 : 32'h8000_0000;
      send_quat(q);
   endtask

   task automatic test_identity();
      quat_pair_type q;
      foreach (q[i]) q[i] = '0;
      q[3] = 32'd1 << FRAC_BITS;
      q[7] = 32'd1 << FRAC_BITS;
      send_quat(q);
      // tiny magnitudes still normalize to unit length
      q[3] = 32'd1;
      q[7] = 32'd1;
      send_quat(q);
      q[0] = 32'd1 << FRAC_BITS; q[3] = 32'd1 << FRAC_BITS;
      q[5] = 32'hffff_fff3; q[7] = 32'd7;
      send_quat(q);
   endtask

   task automatic test_extremes();
      quat_pair_type q;
      foreach (q[i]) q[i] = 32'h8000_0000;
      send_quat(q);
      foreach (q[i]) q[i] = 32'h7fff_ffff;
      send_quat(q);
      foreach (q[i]) q[i] = (i % 2) ? 32'h7fff_ffff : 32'h8000_0000;
      send_quat(q);
      foreach (q[i]) q[i] = (i < 4) ? 32'h8000_0000 : 32'h7fff_ffff;
      send_quat(q);
      foreach (q[i]) q[i] = 32'hffff_ffff;
      send_quat(q);
      foreach (q[i]) q[i] = 32'h5555_5555 ^ {32{i[0]}};
      send_quat(q);
   endtask

   task automatic test_zero_scalar();
      quat_pair_type q;
      // pure vector product with pw exactly zero and negative x
      foreach (q[i]) q[i] = '0;
      q[0] = 32'hc000_0000;
      q[7] = 32'd1 << FRAC_BITS;
      send_quat(q);
      foreach (q[i]) q[i] = '0;
      q[0] = 32'd1 << FRAC_BITS;
      q[5] = 32'hc000_0000;
      send_quat(q);
      // av . bv cancels aw*bw exactly
      foreach (q[i]) q[i] = '0;
      q[0] = 32'd3; q[3] = 32'd5; q[4] = 32'd5; q[7] = 32'd3;
      send_quat(q);
   endtask

   task automatic test_negative_scalar();
      quat_pair_type q;
      foreach (q[i]) q[i] = '0;
      q[3] = 32'hc000_0000;
      q[7] = 32'd1 << FRAC_BITS;
      send_quat(q);
      foreach (q[i]) q[i] = 32'd1 << (FRAC_BITS - 2);
      q[3] = 32'hf000_0000;
      send_quat(q);
      // dot product dominates the scalar
      foreach (q[i]) q[i] = '0;
      q[0] = 32'h4000_0000; q[4] = 32'h4000_0000; q[1] = 32'h2000_0000; q[7] = 32'd9;
      send_quat(q);
   endtask

   task automatic test_random_mix(input int count);
      quat_pair_type q;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 3) == 0)
            foreach (q[i]) q[i] = $urandom;
         else
            foreach (q[i]) q[i] = rand_comp();
         send_quat(q);
      end
   endtask

   task automatic test_backpressure();
      quat_pair_type q;
      no_idle = 1'b1;
      hold_request = 1'b1;
      for (int k = 0; k < 3 * PIPE_DEPTH + 20; k++) begin
         foreach (q[i]) q[i] = $urandom;
         send_quat(q);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_no_idle(input int count);
      no_idle = 1'b1;
      test_random_mix(count);
      no_idle = 1'b0;
   endtask

   // receiver: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request && hold_left == 0) begin
         hold_request <= 1'b0;
         hold_left <= 300;
         rsp_stall <= 1'b1;
      end else if (hold_left > 1) begin
         hold_left <= hold_left - 1;
      end else if (hold_left == 1) begin
         hold_left <= 0;
         rsp_stall <= 1'b0;
      end else if (no_idle) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= pick_gap();
         rsp_stall <= ($urandom_range(0, 1) == 0);
      end
   end

   // result checker against the oldest expected rotation
   always @(posedge clock) begin
      unit_quat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rots.size() == 0) begin
            $display("%0t: unexpected beat x=%h y=%h z=%h w=%h zn=%b", $time,
                     rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_w, rsp_zero_norm);
            errors++;
         end else begin
            e = expected_rots.pop_front();
            if (rsp_r_x !== e.x) begin
               $display("%0t: r_x expected %h actual %h", $time, e.x, rsp_r_x);
               errors++;
            end
            if (rsp_r_y !== e.y) begin
               $display("%0t: r_y expected %h actual %h", $time, e.y, rsp_r_y);
               errors++;
            end
            if (rsp_r_z !== e.z) begin
               $display("%0t: r_z expected %h actual %h", $time, e.z, rsp_r_z);
               errors++;
            end
            if (rsp_r_w !== e.w) begin
               $display("%0t: r_w expected %h actual %h", $time, e.w, rsp_r_w);
               errors++;
            end
            if (rsp_zero_norm !== e.zn) begin
               $display("%0t: zero_norm expected %b actual %b", $time, e.zn,
                        rsp_zero_norm);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("quaternion_multiply_normalize_tb failed");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_product();
      test_identity();
      test_extremes();
      test_zero_scalar();
      test_negative_scalar();
      test_random_mix(900);
      test_backpressure();
      test_no_idle(300);
      test_random_mix(700);
      req_valid <= 1'b0;
      while (expected_rots.size() != 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (errors == 0)
         $display("quaternion_multiply_normalize_tb passed");
      else
         $display("quaternion_multiply_normalize_tb failed");
      $finish;
   end
endmodule
